// ===== design/dbcs_case_insensitive_substring_find_assert.svh =====
// assertion macros for the checker file
`ifndef DBCS_CASE_INSENSITIVE_SUBSTRING_FIND_ASSERT_SVH
`define DBCS_CASE_INSENSITIVE_SUBSTRING_FIND_ASSERT_SVH

// same-cycle implication
`define DCISF_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DCISF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/dcisf_pkg.sv =====
package dcisf_pkg;

    localparam int BYTE_W  = 8;
    localparam int CFG_W   = 64;
    localparam int LEN_IN_W = 4;
    localparam int POS_W   = 16;
    localparam int NEEDLE_REG_BYTES = CFG_W / BYTE_W;

    // a byte with this bit set opens a two-byte character
    localparam logic [BYTE_W-1:0] LEAD_MASK = 8'h80;
    localparam logic [BYTE_W-1:0] UPPER_A   = 8'h41;
    localparam logic [BYTE_W-1:0] UPPER_Z   = 8'h5A;
    localparam logic [BYTE_W-1:0] CASE_BIT  = 8'h20;

    typedef enum logic {
        CFG_NEEDLE_BYTES  = 1'b0,
        CFG_NEEDLE_LENGTH = 1'b1
    } cfg_index_t;

    function automatic logic [BYTE_W-1:0] fold_case(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] r;
        r = c;
        if (c >= UPPER_A && c <= UPPER_Z) begin
            r = c | CASE_BIT;
        end
        return r;
    endfunction

endpackage

// ===== design/dbcs_case_insensitive_substring_find.sv =====
// Streaming substring finder for double-byte text. Bytes enter on the s_ channel,
// one per transaction, with s_last_byte marking the end of a text. The needle
// (cfg index 0, first byte in the low eight bits) is compared against the newest
// bytes with ASCII A-Z folded to lower case; a match counts only when its first
// byte starts a character, where a byte with bit 7 set opens a two-byte character.
// The first match of a text is reported once, as soon as its last byte arrives;
// a text without a match yields found = 0 on its last byte. A needle length of
// zero (cfg index 1) matches at the current byte offset. The byte offset saturates
// at 2^POSITION_BITS - 1, and bytes arriving at that limit end no match.
// Throughput is one byte per clock while no result stalls: an input register
// feeds a single compare stage (byte mux plus NEEDLE_MAX byte compares) that
// loads the result register behind m_valid. The user must write configuration
// only while no text is in flight; this is not enforced. cfg_ready is always high.
module dbcs_case_insensitive_substring_find
    import dcisf_pkg::*;
#(
    parameter int NEEDLE_MAX    = 8,
    parameter int POSITION_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  cfg_index_t           cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [BYTE_W-1:0]    s_haystack_byte,
    input  logic                 s_last_byte,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_found,
    output logic [POS_W-1:0]     m_match_position
);

    localparam int WIN_W = NEEDLE_MAX * BYTE_W;
    localparam int LEN_W = (NEEDLE_MAX > 1) ? $clog2(NEEDLE_MAX + 1) : 1;
    localparam int SUM_W = (POSITION_BITS + 1 > POS_W) ? POSITION_BITS + 1 : POS_W;
    localparam logic [POSITION_BITS-1:0] POS_LIMIT = '1;

    // configuration
    logic [CFG_W-1:0]    needle_bytes_reg;
    logic [LEN_IN_W-1:0] needle_length_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            needle_bytes_reg  <= '0;
            needle_length_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_NEEDLE_BYTES:  needle_bytes_reg  <= cfg_data;
                CFG_NEEDLE_LENGTH: needle_length_reg <= cfg_data[LEN_IN_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_last_reg;
    logic              advance;

    assign advance = in_valid_reg && (!m_valid || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_haystack_byte;
            in_last_reg <= s_last_byte;
        end
    end

    // per-text state
    logic [WIN_W-1:0]         recent_reg;
    logic [NEEDLE_MAX-1:0]    marks_reg;
    logic                     starts_char_reg;
    logic [POSITION_BITS-1:0] bytes_seen_reg;
    logic                     answer_given_reg;

    logic [WIN_W-1:0]         recent_next;
    logic [NEEDLE_MAX-1:0]    marks_next;
    logic                     starts_char_next;
    logic [POSITION_BITS-1:0] bytes_seen_next;
    logic                     answer_given_next;

    logic [LEN_W-1:0]  len;
    logic [LEN_W-1:0]  shamt;
    logic [WIN_W-1:0]  rev_win;
    logic [WIN_W-1:0]  aligned;
    logic [WIN_W-1:0]  pattern;
    logic [NEEDLE_MAX-1:0] byte_ok;
    logic [NEEDLE_MAX-1:0] marks_shifted;
    logic              in_range;
    logic              long_enough;
    logic              hit;
    logic              emit;
    logic [SUM_W-1:0]  pos_full;
    logic [SUM_W-1:0]  seen_plus_one;

    always_comb begin
        recent_next   = (recent_reg << BYTE_W) | WIN_W'(in_byte_reg);
        marks_next    = (marks_reg << 1) | NEEDLE_MAX'(starts_char_reg);
        starts_char_next = !(starts_char_reg && ((in_byte_reg & LEAD_MASK) != '0));
        in_range      = bytes_seen_reg != POS_LIMIT;
        bytes_seen_next = in_range ? bytes_seen_reg + 1'b1 : bytes_seen_reg;

        if (32'(needle_length_reg) > NEEDLE_MAX) begin
            len = LEN_W'(NEEDLE_MAX);
        end else begin
            len = LEN_W'(needle_length_reg);
        end

        // reversed window: oldest slot first, then slide so byte k lines up
        // with needle byte k
        for (int k = 0; k < NEEDLE_MAX; k++) begin
            rev_win[k*BYTE_W +: BYTE_W] = recent_next[(NEEDLE_MAX-1-k)*BYTE_W +: BYTE_W];
            if (k < NEEDLE_REG_BYTES) begin
                pattern[k*BYTE_W +: BYTE_W] = needle_bytes_reg[(k % NEEDLE_REG_BYTES)*BYTE_W
                                                               +: BYTE_W];
            end else begin
                pattern[k*BYTE_W +: BYTE_W] = '0;
            end
        end
        shamt   = LEN_W'(NEEDLE_MAX) - len;
        aligned = rev_win >> (BYTE_W * shamt);

        for (int k = 0; k < NEEDLE_MAX; k++) begin
            byte_ok[k] = (LEN_W'(k) >= len) ||
                         (fold_case(aligned[k*BYTE_W +: BYTE_W]) ==
                          fold_case(pattern[k*BYTE_W +: BYTE_W]));
        end

        // start slot of a match of this length must open a character
        marks_shifted = marks_next >> (len - 1'b1);
        seen_plus_one = SUM_W'(bytes_seen_reg) + SUM_W'(1);
        long_enough   = seen_plus_one >= SUM_W'(len);

        hit      = 1'b0;
        pos_full = '0;
        if (!answer_given_reg && in_range) begin
            if (len == '0) begin
                hit      = 1'b1;
                pos_full = SUM_W'(bytes_seen_reg);
            end else if (long_enough && marks_shifted[0] && (&byte_ok)) begin
                hit      = 1'b1;
                pos_full = seen_plus_one - SUM_W'(len);
            end
        end

        emit = hit || (in_last_reg && !answer_given_reg);
        answer_given_next = answer_given_reg || hit;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            marks_reg        <= '0;
            starts_char_reg  <= 1'b1;
            bytes_seen_reg   <= '0;
            answer_given_reg <= 1'b0;
        end else if (advance) begin
            if (in_last_reg) begin
                marks_reg        <= '0;
                starts_char_reg  <= 1'b1;
                bytes_seen_reg   <= '0;
                answer_given_reg <= 1'b0;
            end else begin
                marks_reg        <= marks_next;
                starts_char_reg  <= starts_char_next;
                bytes_seen_reg   <= bytes_seen_next;
                answer_given_reg <= answer_given_next;
            end
        end
    end

    // window contents are qualified by the byte count and marks
    always_ff @(posedge aclk) begin
        if (advance) begin
            recent_reg <= recent_next;
        end
    end

    // result register
    logic             out_valid_reg;
    logic             out_found_reg;
    logic [POS_W-1:0] out_pos_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && emit) begin
            out_found_reg <= hit;
            out_pos_reg   <= pos_full[POS_W-1:0];
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_found          = out_found_reg;
    assign m_match_position = out_pos_reg;

endmodule

// ===== design/dcisf_checker.sv =====
`include "dbcs_case_insensitive_substring_find_assert.svh"

module dcisf_checker
    import dcisf_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input logic              m_found,
    input logic [POS_W-1:0]  m_match_position
);

    // a stalled result holds
    `DCISF_ASSERT_NEXT(a_result_held, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_found) && $stable(m_match_position), "result changed while stalled")

    // not-found carries a zero offset
    `DCISF_ASSERT_NOW(a_notfound_zero, aclk, aresetn, m_valid && !m_found, m_match_position == '0, "not-found with nonzero offset")

    // input backpressure only comes from a stalled result
    `DCISF_ASSERT_NOW(a_ready_cause, aclk, aresetn, !s_ready, m_valid && !m_ready, "input stalled without output stall")

    // nothing pending right out of reset
    `DCISF_ASSERT_NOW(a_empty_after_reset, aclk, aresetn, $past(!aresetn), !m_valid, "result valid right after reset")

endmodule

bind dbcs_case_insensitive_substring_find dcisf_checker u_dcisf_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_found          (m_found),
    .m_match_position (m_match_position)
);

// ===== dv/tb_dbcs_case_insensitive_substring_find.sv =====
`timescale 1ns / 100ps

module tb_dbcs_case_insensitive_substring_find;
    import dcisf_pkg::*;

    localparam int SLOTS            = 8;
    localparam int POS_SAT          = (1 << POS_W) - 1;
    localparam int DRAIN_CYCLES     = 8;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int PHASE_BYTES      = 88;
    localparam int LIMIT_NS         = 10_000_000;

    typedef struct {
        logic             found;
        logic [POS_W-1:0] position;
    } answer_t;

    // tracks one text at a time and predicts the single answer it gives
    class first_match_predictor;
        logic [CFG_W-1:0]    needle;
        logic [LEN_IN_W-1:0] needle_len;
        logic [BYTE_W-1:0]   window [SLOTS];
        logic [SLOTS-1:0]    char_starts;
        bit                  next_is_start;
        int unsigned         offset;
        bit                  answered;
        answer_t             expected_answers [$];
        int                  mismatches;

        function new();
            needle     = '0;
            needle_len = '0;
            mismatches = 0;
            restart_text();
        endfunction

        function void restart_text();
            foreach (window[i]) window[i] = '0;
            char_starts   = '0;
            next_is_start = 1'b1;
            offset        = 0;
            answered      = 1'b0;
        endfunction

        function logic [BYTE_W-1:0] to_lower(logic [BYTE_W-1:0] c);
            if (c >= UPPER_A && c <= UPPER_Z) begin
                return c | CASE_BIT;
            end
            return c;
        endfunction

        function void write_reg(cfg_index_t idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_NEEDLE_BYTES: begin
                    needle = data;
                end
                CFG_NEEDLE_LENGTH: begin
                    needle_len = data[LEN_IN_W-1:0];
                end
            endcase
        endfunction

        function void accept_byte(logic [BYTE_W-1:0] b, logic last);
            bit          starts;
            bit          in_range;
            bit          hit;
            bit          same;
            int unsigned p;
            int unsigned len;
            int unsigned hit_pos;
            answer_t     a;
            starts   = next_is_start;
            p        = offset;
            in_range = p < POS_SAT;
            hit      = 1'b0;
            hit_pos  = 0;
            // a lead byte makes the following byte a trail byte
            next_is_start = !(starts && ((b & LEAD_MASK) != 0));
            for (int i = SLOTS - 1; i > 0; i--) window[i] = window[i-1];
            window[0]   = b;
            char_starts = {char_starts[SLOTS-2:0], starts};
            if (in_range) begin
                offset = p + 1;
            end
            len = (needle_len > SLOTS) ? SLOTS : needle_len;
            if (!answered && in_range) begin
                if (len == 0) begin
                    hit     = 1'b1;
                    hit_pos = p;
                end else if (p + 1 >= len && char_starts[len-1]) begin
                    same = 1'b1;
                    for (int k = 0; k < len; k++) begin
                        if (to_lower(window[len-1-k]) != to_lower(needle[BYTE_W*k +: BYTE_W]))
                            same = 1'b0;
                    end
                    if (same) begin
                        hit     = 1'b1;
                        hit_pos = p + 1 - len;
                    end
                end
            end
            if (hit) begin
                answered   = 1'b1;
                a.found    = 1'b1;
                a.position = POS_W'(hit_pos);
                expected_answers.push_back(a);
            end else if (last && !answered) begin
                a.found    = 1'b0;
                a.position = '0;
                expected_answers.push_back(a);
            end
            if (last) begin
                restart_text();
            end
        endfunction

        function void check_answer(logic found, logic [POS_W-1:0] position);
            answer_t want;
            if (expected_answers.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result found=%0b position=%0d",
                             $time, found, position);
                return;
            end
            want = expected_answers.pop_front();
            if (found !== want.found || position !== want.position) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: expected found=%0b position=%0d, got found=%0b position=%0d",
                             $time, want.found, want.position, found, position);
            end
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_valid;
    logic                 cfg_ready;
    cfg_index_t           cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 s_valid;
    logic                 s_ready;
    logic [BYTE_W-1:0]    s_haystack_byte;
    logic                 s_last_byte;
    logic                 m_valid;
    logic                 m_ready;
    logic                 m_found;
    logic [POS_W-1:0]     m_match_position;

    first_match_predictor oracle;
    bit                   src_idle_on;
    bit                   sink_idle_on;
    bit                   long_hold_req;
    int                   bytes_sent;

    dbcs_case_insensitive_substring_find dut (
        .aclk,
        .aresetn,
        .cfg_valid,
        .cfg_ready,
        .cfg_index,
        .cfg_data,
        .s_valid,
        .s_ready,
        .s_haystack_byte,
        .s_last_byte,
        .m_valid,
        .m_ready,
        .m_found,
        .m_match_position
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #(LIMIT_NS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) oracle.check_answer(m_found, m_match_position);
            if (cfg_valid && cfg_ready) oracle.write_reg(cfg_index, cfg_data);
            if (s_valid && s_ready) oracle.accept_byte(s_haystack_byte, s_last_byte);
        end
    end

    function automatic int pick_gap(bit enabled);
        int r;
        r = $urandom_range(0, 99);
        if (!enabled || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [BYTE_W-1:0] flip_case(logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] low;
        low = c | CASE_BIT;
        if (low >= (UPPER_A | CASE_BIT) && low <= (UPPER_Z | CASE_BIT) && $urandom_range(0, 1))
            return c ^ CASE_BIT;
        return c;
    endfunction

    function automatic logic [BYTE_W-1:0] pick_plain_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) return BYTE_W'($urandom_range(0, 255));
        if (r < 50) return BYTE_W'($urandom_range(128, 255));
        if (r < 85) return flip_case(BYTE_W'(UPPER_A + $urandom_range(0, 25)));
        return 8'h00;
    endfunction

    function automatic logic [CFG_W-1:0] random_needle();
        logic [CFG_W-1:0] pattern;
        for (int k = 0; k < NEEDLE_REG_BYTES; k++) pattern[BYTE_W*k +: BYTE_W] = pick_plain_byte();
        return pattern;
    endfunction

    // pulls text bytes from the needle often so partial matches are common
    function automatic logic [BYTE_W-1:0] pick_text_byte(logic [CFG_W-1:0] pattern, int eff_len);
        if (eff_len > 0 && $urandom_range(0, 99) < 40)
            return flip_case(pattern[BYTE_W*$urandom_range(0, eff_len - 1) +: BYTE_W]);
        return pick_plain_byte();
    endfunction

    task automatic send_byte(logic [BYTE_W-1:0] b, logic last);
        int gap;
        s_valid         <= 1'b1;
        s_haystack_byte <= b;
        s_last_byte     <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bytes_sent++;
        gap = pick_gap(src_idle_on);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_text(input logic [BYTE_W-1:0] t [$]);
        foreach (t[i]) send_byte(t[i], i == t.size() - 1);
    endtask

    task automatic send_random_text(logic [CFG_W-1:0] pattern, int eff_len, int max_len);
        logic [BYTE_W-1:0] t [$];
        int                n;
        int                at;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, max_len);
        for (int i = 0; i < n; i++) t.push_back(pick_text_byte(pattern, eff_len));
        if (eff_len > 0 && $urandom_range(0, 1)) begin
            at = $urandom_range(0, n);
            for (int k = 0; k < eff_len; k++)
                t.insert(at + k, flip_case(pattern[BYTE_W*k +: BYTE_W]));
        end
        send_text(t);
    endtask

    task automatic load_needle(logic [CFG_W-1:0] pattern, logic [LEN_IN_W-1:0] len);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_NEEDLE_BYTES;
        cfg_data  <= pattern;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        // upper bits of the length write carry junk the block must ignore
        cfg_index <= CFG_NEEDLE_LENGTH;
        cfg_data  <= {32'($urandom()), 28'($urandom()), len};
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic end_phase();
        s_valid <= 1'b0;
        while (oracle.expected_answers.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin
        int run;
        int gap;
        m_ready = 1'b0;
        @(posedge aclk);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge aclk);
            end else begin
                run = $urandom_range(1, 20);
                m_ready <= 1'b1;
                repeat (run) @(posedge aclk);
                gap = pick_gap(sink_idle_on);
                if (gap > 0) begin
                    m_ready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
        end
    end

    initial begin
        logic [BYTE_W-1:0]   t [$];
        logic [CFG_W-1:0]    pattern;
        logic [LEN_IN_W-1:0] len;
        int                  eff;
        int                  phase_end;
        oracle          = new();
        aresetn         = 1'b0;
        cfg_valid       = 1'b0;
        cfg_index       = CFG_NEEDLE_BYTES;
        cfg_data        = '0;
        s_valid         = 1'b0;
        s_haystack_byte = '0;
        s_last_byte     = 1'b0;
        src_idle_on     = 1'b1;
        sink_idle_on    = 1'b1;
        long_hold_req   = 1'b0;
        bytes_sent      = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // needle still empty after reset: hit on the first byte, silent last byte
        t = {8'hFF, 8'h00};
        send_text(t);
        end_phase();

        load_needle({40'h0, 8'h00, 8'h62, 8'h41}, 4'd3);
        t = {8'h61, 8'h42, 8'h00};
        send_text(t);
        // needle sitting on a trail byte must not match
        t = {8'h81, 8'h41, 8'h62, 8'h00, 8'h78};
        send_text(t);
        t = {8'h81, 8'h81, 8'h61, 8'h42, 8'h00, 8'h00};
        send_text(t);
        end_phase();

        // length beyond the window is clamped to eight bytes
        load_needle(64'h00FF_5A41_7A61_2040, 4'd12);
        t = {8'h40, 8'h20, 8'h41, 8'h5A, 8'h61, 8'h7A, 8'hFF, 8'h00};
        send_text(t);
        t = {8'h00};
        send_text(t);
        end_phase();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin
                    pattern = random_needle();
                    len     = 4'd0;
                end
                1: begin
                    pattern = '1;
                    len     = 4'd8;
                end
                2: begin
                    pattern = '0;
                    len     = 4'd15;
                end
                default: begin
                    pattern = random_needle();
                    len     = LEN_IN_W'($urandom_range(1, SLOTS));
                end
            endcase
            src_idle_on  = (ph != 5);
            sink_idle_on = (ph != 5);
            load_needle(pattern, len);
            eff = (len > SLOTS) ? SLOTS : len;
            // sink stalls while short texts keep coming, so the block backs up
            if (ph == 3) long_hold_req = 1'b1;
            phase_end = bytes_sent + PHASE_BYTES;
            while (bytes_sent < phase_end)
                send_random_text(pattern, eff, (ph == 3) ? 3 : 16);
            end_phase();
        end

        if (oracle.expected_answers.size() != 0)
            $display("%0d expected results never arrived", oracle.expected_answers.size());
        if (oracle.mismatches == 0 && oracle.expected_answers.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
